[sv/char_lcd_4bit_sequencer_core_defines.svh]
// assertion macros for the character lcd sequencer core
// included by modules that carry concurrent checks; no other dependencies
`ifndef CHAR_LCD_4BIT_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_4BIT_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLSQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clsq check failed");

// next-cycle implication, disabled during reset
`define CLSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clsq check failed");

`endif

[sv/clsq_pkg.sv]
// shared types and constants for the character lcd sequencer core
// no dependencies
package clsq_pkg;

  typedef struct packed {
    logic [16:0] powerup_ticks;
    logic [15:0] cmd_extra_ticks;
    logic [15:0] post_latch_ticks;
    logic [7:0]  en_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] value_byte;
  } beat_t;

  typedef struct packed {
    logic       rejected;
    logic       busy_res;
    logic [3:0] bus_nibble;
    logic       en_line;
    logic       rs_line;
  } res_t;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;
  localparam logic [1:0] REQ_INIT = 2'd3;

  localparam logic [1:0] REG_EN_HIGH    = 2'd0;
  localparam logic [1:0] REG_POST_LATCH = 2'd1;
  localparam logic [1:0] REG_CMD_EXTRA  = 2'd2;
  localparam logic [1:0] REG_POWERUP    = 2'd3;

  localparam logic [7:0]  EN_HIGH_RST    = 8'd1;
  localparam logic [15:0] POST_LATCH_RST = 16'd100;
  localparam logic [15:0] CMD_EXTRA_RST  = 16'd2000;
  localparam logic [16:0] POWERUP_RST    = 17'd100000;

  localparam logic [16:0] INIT_WAIT_LONG  = 17'd5000;
  localparam logic [16:0] INIT_WAIT_SHORT = 17'd200;
  localparam logic [16:0] FINAL_WAIT      = 17'd5000;

  localparam logic [3:0] INIT_NIB_WAKE = 4'h3;
  localparam logic [3:0] INIT_NIB_4BIT = 4'h2;

  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;

  // init step codes
  localparam logic [3:0] STEP_NONE   = 4'd0;
  localparam logic [3:0] STEP_FIRST  = 4'd1;
  localparam logic [3:0] STEP_SECOND = 4'd2;
  localparam logic [3:0] STEP_LAST   = 4'd4;
  localparam logic [3:0] STEP_FUNC   = 4'd5;
  localparam logic [3:0] STEP_DISP   = 4'd6;
  localparam logic [3:0] STEP_CLEAR  = 4'd7;
  localparam logic [3:0] STEP_FINAL  = 4'd8;

endpackage

[sv/char_lcd_4bit_sequencer_core.sv]
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata value_byte, tuser req_type
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata pin levels and status
// apb       in   psel, penable, pwrite, pready  timing registers at 0x0..0xc
// one tick per cycle while m_axis_tready keeps the result moving: a beat is
// registered, updated through the sequencer and held in the result register
// rst is synchronous and clears control state and timing registers to defaults
// while a result waits the input register still takes one beat, then holds
// s_axis_tready low until the result is taken; no beat is dropped
module char_lcd_4bit_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] value_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] rs_line, [1] en_line, [5:2] bus_nibble,
                                      // [6] busy_res, [7] rejected
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  clsq_pkg::cfg_t  cfg;
  clsq_pkg::beat_t in_beat;
  clsq_pkg::beat_t q_beat;
  clsq_pkg::res_t  res;
  logic            q_valid;
  logic            q_take;

  assign in_beat.req_type   = s_axis_tuser;
  assign in_beat.value_byte = s_axis_tdata;
  assign m_axis_tdata       = res;

  clsq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clsq_inreg u_inreg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_beat   (in_beat),
    .out_valid (q_valid),
    .out_take  (q_take),
    .out_beat  (q_beat)
  );

  clsq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_valid),
    .in_beat   (q_beat),
    .in_take   (q_take),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

endmodule

[sv/clsq_cfg.sv]
// apb register file for the character lcd sequencer timing settings
// depends on clsq_pkg
module clsq_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output clsq_pkg::cfg_t  cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.en_high_ticks    <= clsq_pkg::EN_HIGH_RST;
      cfg.post_latch_ticks <= clsq_pkg::POST_LATCH_RST;
      cfg.cmd_extra_ticks  <= clsq_pkg::CMD_EXTRA_RST;
      cfg.powerup_ticks    <= clsq_pkg::POWERUP_RST;
    end else if (wr) begin
      unique case (idx)
        clsq_pkg::REG_EN_HIGH:    cfg.en_high_ticks    <= pwdata[7:0];
        clsq_pkg::REG_POST_LATCH: cfg.post_latch_ticks <= pwdata[15:0];
        clsq_pkg::REG_CMD_EXTRA:  cfg.cmd_extra_ticks  <= pwdata[15:0];
        clsq_pkg::REG_POWERUP:    cfg.powerup_ticks    <= pwdata[16:0];
        default:                  cfg.en_high_ticks    <= cfg.en_high_ticks;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      clsq_pkg::REG_EN_HIGH:    prdata = {24'd0, cfg.en_high_ticks};
      clsq_pkg::REG_POST_LATCH: prdata = {16'd0, cfg.post_latch_ticks};
      clsq_pkg::REG_CMD_EXTRA:  prdata = {16'd0, cfg.cmd_extra_ticks};
      clsq_pkg::REG_POWERUP:    prdata = {15'd0, cfg.powerup_ticks};
      default:                  prdata = '0;
    endcase
  end

endmodule

[sv/clsq_inreg.sv]
// input register stage: captures one request beat per cycle while in_ready is high
// depends on clsq_pkg
module clsq_inreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  clsq_pkg::beat_t  in_beat,
  output logic             out_valid,
  input  logic             out_take,
  output clsq_pkg::beat_t  out_beat
);

  logic valid;
  clsq_pkg::beat_t beat;

  assign in_ready  = !valid || out_take;
  assign out_valid = valid;
  assign out_beat  = beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (out_take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat <= in_beat;
    end
  end

endmodule

[sv/clsq_seq.sv]
// sequencer state and one-tick update logic, with the result register
// depends on clsq_pkg and char_lcd_4bit_sequencer_core_defines.svh
`include "char_lcd_4bit_sequencer_core_defines.svh"

module clsq_seq (
  input  logic             clk,
  input  logic             rst,
  input  clsq_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  clsq_pkg::beat_t  in_beat,
  output logic             in_take,
  output logic             res_valid,
  input  logic             res_ready,
  output clsq_pkg::res_t   res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_POWER, PH_INEN, PH_INPOST, PH_INWAIT,
    PH_HIEN, PH_HIPOST, PH_LOEN, PH_LOPOST, PH_EXTRA, PH_FINAL
  } phase_t;

  typedef struct packed {
    phase_t      ph;
    logic [16:0] wc;
    logic [7:0]  held;
    logic        rs;
    logic [3:0]  nib;
    logic [3:0]  step;
  } st_t;

  // end of a byte: next init command, final wait or idle
  function automatic st_t byte_done(st_t s);
    st_t r;
    r = s;
    if (s.step == clsq_pkg::STEP_FUNC) begin
      r.step = clsq_pkg::STEP_DISP;
      r.held = clsq_pkg::CMD_DISP_ON;
      r.rs   = 1'b0;
      r.ph   = PH_HIEN;
    end else if (s.step == clsq_pkg::STEP_DISP) begin
      r.step = clsq_pkg::STEP_CLEAR;
      r.held = clsq_pkg::CMD_CLEAR;
      r.rs   = 1'b0;
      r.ph   = PH_HIEN;
    end else if (s.step == clsq_pkg::STEP_CLEAR) begin
      r.step = clsq_pkg::STEP_FINAL;
      r.ph   = PH_FINAL;
    end else begin
      r.step = clsq_pkg::STEP_NONE;
      r.ph   = PH_IDLE;
    end
    return r;
  endfunction

  function automatic st_t after_f(st_t s);
    st_t r;
    r = s;
    unique case (s.ph)
      PH_POWER:  r.ph = PH_INEN;
      PH_INEN:   r.ph = PH_INPOST;
      PH_INPOST: r.ph = PH_INWAIT;
      PH_INWAIT: begin
        if (s.step < clsq_pkg::STEP_LAST) begin
          r.step = s.step + 4'd1;
          r.ph   = PH_INEN;
        end else begin
          r.step = clsq_pkg::STEP_FUNC;
          r.held = clsq_pkg::CMD_FUNC_SET;
          r.rs   = 1'b0;
          r.ph   = PH_HIEN;
        end
      end
      PH_HIEN:   r.ph = PH_HIPOST;
      PH_HIPOST: r.ph = PH_LOEN;
      PH_LOEN:   r.ph = PH_LOPOST;
      PH_LOPOST: begin
        if (!s.rs) r.ph = PH_EXTRA;
        else       r = byte_done(s);
      end
      PH_EXTRA:  r = byte_done(s);
      default: begin
        r.step = clsq_pkg::STEP_NONE;
        r.ph   = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // enter a phase, passing over segments of zero length
  function automatic st_t settle(st_t s0, clsq_pkg::cfg_t c);
    st_t         s;
    logic        done;
    logic [16:0] dur;
    logic [7:0]  enh;
    s    = s0;
    done = 1'b0;
    enh  = (c.en_high_ticks == 8'd0) ? 8'd1 : c.en_high_ticks;
    for (int i = 0; i < 4; i++) begin
      if (!done) begin
        dur = '0;
        unique case (s.ph)
          PH_POWER: dur = c.powerup_ticks;
          PH_INEN: begin
            s.nib = (s.step == clsq_pkg::STEP_LAST) ? clsq_pkg::INIT_NIB_4BIT
                                                    : clsq_pkg::INIT_NIB_WAKE;
            dur   = {9'd0, enh};
          end
          PH_HIEN: begin
            s.nib = s.held[7:4];
            dur   = {9'd0, enh};
          end
          PH_LOEN: begin
            s.nib = s.held[3:0];
            dur   = {9'd0, enh};
          end
          PH_INPOST, PH_HIPOST, PH_LOPOST: dur = {1'b0, c.post_latch_ticks};
          PH_INWAIT: begin
            if (s.step == clsq_pkg::STEP_FIRST)       dur = clsq_pkg::INIT_WAIT_LONG;
            else if (s.step == clsq_pkg::STEP_SECOND) dur = clsq_pkg::INIT_WAIT_SHORT;
            else                                      dur = '0;
          end
          PH_EXTRA: dur = {1'b0, c.cmd_extra_ticks};
          PH_FINAL: dur = clsq_pkg::FINAL_WAIT;
          default:  dur = '0;
        endcase
        if (s.ph == PH_IDLE) begin
          s.wc = '0;
          done = 1'b1;
        end else if (dur != 17'd0) begin
          s.wc = dur;
          done = 1'b1;
        end else begin
          s = after_f(s);
        end
      end
    end
    return s;
  endfunction

  st_t            cur;
  st_t            nxt;
  st_t            tmp;
  logic           rej;
  logic           load;
  logic           en_n;
  logic [16:0]    wc_dec;
  clsq_pkg::res_t res_next;

  assign load    = in_valid && (!res_valid || res_ready);
  assign in_take = load;

  always_comb begin
    nxt    = cur;
    tmp    = cur;
    rej    = 1'b0;
    wc_dec = (cur.wc != 17'd0) ? cur.wc - 17'd1 : 17'd0;
    if (cur.ph != PH_IDLE) begin
      rej    = (in_beat.req_type != clsq_pkg::REQ_TICK);
      tmp.wc = wc_dec;
      if (wc_dec == 17'd0) nxt = settle(after_f(tmp), cfg);
      else                 nxt = tmp;
    end else if (in_beat.req_type == clsq_pkg::REQ_CMD ||
                 in_beat.req_type == clsq_pkg::REQ_DATA) begin
      tmp.held = in_beat.value_byte;
      tmp.rs   = (in_beat.req_type == clsq_pkg::REQ_DATA);
      tmp.step = clsq_pkg::STEP_NONE;
      tmp.ph   = PH_HIEN;
      nxt      = settle(tmp, cfg);
    end else if (in_beat.req_type == clsq_pkg::REQ_INIT) begin
      tmp.rs   = 1'b0;
      tmp.step = clsq_pkg::STEP_FIRST;
      tmp.ph   = PH_POWER;
      nxt      = settle(tmp, cfg);
    end
    en_n = (nxt.ph == PH_INEN) || (nxt.ph == PH_HIEN) || (nxt.ph == PH_LOEN);
    res_next.rs_line    = nxt.rs;
    res_next.en_line    = en_n;
    res_next.bus_nibble = nxt.nib;
    res_next.busy_res   = (nxt.ph != PH_IDLE);
    res_next.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.ph    <= PH_IDLE;
      cur.wc    <= '0;
      cur.held  <= '0;
      cur.rs    <= 1'b0;
      cur.nib   <= '0;
      cur.step  <= clsq_pkg::STEP_NONE;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        cur       <= nxt;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  `CLSQ_ASSERT_IMPL(a_idle_no_wait, clk, rst, cur.ph == PH_IDLE, cur.wc == 17'd0)
  `CLSQ_ASSERT_IMPL(a_busy_has_wait, clk, rst, cur.ph != PH_IDLE, cur.wc != 17'd0)
  `CLSQ_ASSERT_NEXT(a_idle_no_reject, clk, rst, load && cur.ph == PH_IDLE, !res.rejected)
  `CLSQ_ASSERT_IMPL(a_strobe_busy, clk, rst, res_valid && res.en_line, res.busy_res)

endmodule
